// File: design/sv32_tlb_page_walker_unit_assert.svh
// Assertion macros used by the page walker control block.
`ifndef SV32_TLB_PAGE_WALKER_UNIT_ASSERT_SVH
`define SV32_TLB_PAGE_WALKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define STPW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define STPW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define STPW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define STPW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: design/stpw_pkg.sv
package stpw_pkg;

    localparam int FETCH_TLB_ENTRIES = 8;
    localparam int DATA_TLB_ENTRIES  = 8;
    localparam int TLB_TOTAL = FETCH_TLB_ENTRIES + DATA_TLB_ENTRIES;
    localparam int TLB_IDX_W = (TLB_TOTAL > 1) ? $clog2(TLB_TOTAL) : 1;
    localparam int FETCH_PTR_W = (FETCH_TLB_ENTRIES > 1) ? $clog2(FETCH_TLB_ENTRIES) : 1;
    localparam int DATA_PTR_W = (DATA_TLB_ENTRIES > 1) ? $clog2(DATA_TLB_ENTRIES) : 1;

    typedef enum logic [1:0] {
        KIND_TRANSLATE = 2'd0,
        KIND_RESPONSE  = 2'd1,
        KIND_FLUSH     = 2'd2,
        KIND_UNUSED    = 2'd3
    } kind_e;

    typedef enum logic [1:0] {
        ACT_PHYS     = 2'd0,
        ACT_PTE_READ = 2'd1,
        ACT_FAULT    = 2'd2,
        ACT_BUSY     = 2'd3
    } action_e;

    localparam logic [1:0] CAUSE_FETCH = 2'd0;
    localparam logic [1:0] CAUSE_LOAD  = 2'd1;
    localparam logic [1:0] CAUSE_STORE = 2'd2;

    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    localparam logic [2:0] CFG_SATP_MODE = 3'd0;
    localparam logic [2:0] CFG_ROOT_PPN  = 3'd1;
    localparam logic [2:0] CFG_ASID      = 3'd2;
    localparam logic [2:0] CFG_MPRV      = 3'd3;
    localparam logic [2:0] CFG_MPP       = 3'd4;
    localparam logic [2:0] CFG_SUM       = 3'd5;
    localparam logic [2:0] CFG_MXR       = 3'd6;

    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;
    localparam int PTE_A = 6;
    localparam int PTE_D = 7;

    typedef struct packed {
        logic        pte_ok;
        logic [31:0] pte_word;
        logic [31:0] cur_pc;
        logic [1:0]  cur_privilege;
        logic        is_store;
        logic        is_fetch;
        logic [31:0] vaddr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  fault_privilege;
        logic [31:0] trap_pc;
        logic [31:0] fault_value;
        logic [1:0]  fault_cause;
        logic        tlb_hit;
        logic [31:0] phys_addr;
    } out_item_t;

    typedef struct packed {
        logic [19:0] tag;
        logic [21:0] root;
        logic [8:0]  asid;
        logic [1:0]  priv;
        logic        sum;
        logic        mxr;
        logic        level;
    } tlb_key_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_result;
    } ctrl_sts_t;

    function automatic logic [1:0] cause_of(logic fetch, logic store);
        return fetch ? CAUSE_FETCH : (store ? CAUSE_STORE : CAUSE_LOAD);
    endfunction

    function automatic logic leaf_allows(logic [31:0] pte, logic fetch, logic store,
                                         logic [1:0] priv, logic sum, logic mxr);
        logic ok;
        ok = fetch ? pte[PTE_X] : (store ? pte[PTE_W] : (pte[PTE_R] | (mxr & pte[PTE_X])));
        if (priv == PRIV_U && !pte[PTE_U])
            ok = 1'b0;
        if (priv == PRIV_S && pte[PTE_U] && (fetch || !sum))
            ok = 1'b0;
        if (!pte[PTE_A])
            ok = 1'b0;
        if (!fetch && store && !pte[PTE_D])
            ok = 1'b0;
        return ok;
    endfunction

endpackage

// File: design/sv32_tlb_page_walker_unit.sv
// Sv32 translation unit with fetch and data TLBs and a two-level page walker.
// Input channel s_axis: tuser carries the kind (translate, PTE response, flush);
// tdata carries the request and response fields. Output channel m_axis: tuser
// carries the action (physical access, PTE read, page fault, busy) and tdata
// the address and fault fields. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata, one register per cycle; the user must write
// them only while idle, as the block itself does not enforce it. Each
// transaction is captured in the idle state; in the execute state all TLB
// keys are looked up in parallel and the hit, the fault checks or the next
// walk step are resolved, and any result is loaded into the output
// register. No new transaction is taken until the execute state is left.
// A TLB miss returns a PTE read request; each PTE response transaction then
// returns either the next read, a fault, or the physical address (the entry
// is filled round robin). Reset clears all valid bits, the walk and the
// configuration. If the receiver stalls, the pending result holds and the
// unit stops accepting once a second result is ready to go out.
module sv32_tlb_page_walker_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // vaddr, is_fetch, is_store, cur_privilege, cur_pc, pte_word, pte_ok
    input  logic [103:0]  s_axis_tdata,
    // kind
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // phys_addr, tlb_hit, fault_cause, fault_value, trap_pc, fault_privilege
    output logic [103:0]  m_axis_tdata,
    // action
    output logic [1:0]    m_axis_tuser,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [21:0]   cfg_wdata
);
    import stpw_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    in_item_t  in_item;
    out_item_t out_item;

    // Unpack the input transaction from the lowest bit up.
    assign in_item.vaddr         = s_axis_tdata[31:0];
    assign in_item.is_fetch      = s_axis_tdata[32];
    assign in_item.is_store      = s_axis_tdata[33];
    assign in_item.cur_privilege = s_axis_tdata[35:34];
    assign in_item.cur_pc        = s_axis_tdata[67:36];
    assign in_item.pte_word      = s_axis_tdata[99:68];
    assign in_item.pte_ok        = s_axis_tdata[100];

    stpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    stpw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_kind    (s_axis_tuser),
        .in_item    (in_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_action (m_axis_tuser),
        .out_item   (out_item)
    );

    // The output struct is declared last field first, so it packs low to high.
    assign m_axis_tdata = {3'b000, out_item};

endmodule

// File: design/stpw_datapath.sv
module stpw_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stpw_pkg::ctrl_cmd_t  cmd,
    output stpw_pkg::ctrl_sts_t  sts,
    input  logic [1:0]           in_kind,
    input  stpw_pkg::in_item_t   in_item,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [21:0]          cfg_wdata,
    output logic [1:0]           out_action,
    output stpw_pkg::out_item_t  out_item
);
    import stpw_pkg::*;

    logic        satp_mode_reg;
    logic [21:0] root_ppn_reg;
    logic [8:0]  asid_reg;
    logic        mprv_reg;
    logic [1:0]  mpp_reg;
    logic        sum_reg;
    logic        mxr_reg;

    logic [1:0]  kind_reg;
    in_item_t    item_reg;

    logic [TLB_TOTAL-1:0] tlb_valid_reg;
    tlb_key_t             tlb_key_reg [TLB_TOTAL];
    logic [31:0]          tlb_leaf_mem [TLB_TOTAL];
    logic [31:0]          tlb_base_mem [TLB_TOTAL];
    logic [FETCH_PTR_W-1:0] fetch_ptr_reg;
    logic [DATA_PTR_W-1:0]  data_ptr_reg;

    logic        walk_active_reg;
    logic [31:0] walk_vaddr_reg;
    logic        walk_fetch_reg;
    logic        walk_store_reg;
    logic [1:0]  walk_priv_reg;
    logic        walk_sum_reg;
    logic        walk_mxr_reg;
    logic        walk_level_reg;
    logic [31:0] walk_pc_reg;

    logic [1:0]  out_action_reg;
    out_item_t   out_item_reg;

    logic        fetch, store;
    logic [1:0]  priv;
    logic [31:0] va, pte;
    logic [TLB_TOTAL-1:0] match;
    logic        hit;
    logic [TLB_IDX_W-1:0] hit_idx;
    logic [31:0] hit_leaf, hit_base, hit_pa, walk_pa;
    logic        hit_level;
    logic [TLB_IDX_W-1:0] fill_slot;
    action_e     res_action;
    out_item_t   res;
    logic        has_result, do_start, do_next, do_fill, do_end, do_flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            satp_mode_reg <= 1'b0;
            root_ppn_reg  <= '0;
            asid_reg      <= '0;
            mprv_reg      <= 1'b0;
            mpp_reg       <= '0;
            sum_reg       <= 1'b0;
            mxr_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SATP_MODE: satp_mode_reg <= cfg_wdata[0];
                CFG_ROOT_PPN:  root_ppn_reg  <= cfg_wdata;
                CFG_ASID:      asid_reg      <= cfg_wdata[8:0];
                CFG_MPRV:      mprv_reg      <= cfg_wdata[0];
                CFG_MPP:       mpp_reg       <= cfg_wdata[1:0];
                CFG_SUM:       sum_reg       <= cfg_wdata[0];
                CFG_MXR:       mxr_reg       <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            item_reg <= in_item;
        end
        if (cmd.load)
        begin
            out_action_reg <= res_action;
            out_item_reg   <= res;
        end
    end

    assign fetch = item_reg.is_fetch;
    assign store = !item_reg.is_fetch && item_reg.is_store;
    assign va    = item_reg.vaddr;
    assign pte   = item_reg.pte_word;
    assign priv  = (!fetch && item_reg.cur_privilege == PRIV_M && mprv_reg) ?
                   mpp_reg : item_reg.cur_privilege;

    // Every key compares in parallel; the tag width follows the entry's level.
    always_comb
    begin
        for (int i = 0; i < TLB_TOTAL; i++)
        begin
            match[i] = tlb_valid_reg[i]
                && tlb_key_reg[i].root == root_ppn_reg
                && tlb_key_reg[i].asid == asid_reg
                && tlb_key_reg[i].priv == priv
                && tlb_key_reg[i].sum == sum_reg
                && tlb_key_reg[i].mxr == mxr_reg
                && (tlb_key_reg[i].level ? (tlb_key_reg[i].tag == {10'd0, va[31:22]})
                                         : (tlb_key_reg[i].tag == va[31:12]));
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        if (fetch)
        begin
            for (int i = FETCH_TLB_ENTRIES - 1; i >= 0; i--)
            begin
                if (match[i])
                begin
                    hit     = 1'b1;
                    hit_idx = TLB_IDX_W'(i);
                end
            end
        end
        else
        begin
            for (int i = TLB_TOTAL - 1; i >= FETCH_TLB_ENTRIES; i--)
            begin
                if (match[i])
                begin
                    hit     = 1'b1;
                    hit_idx = TLB_IDX_W'(i);
                end
            end
        end
    end

    assign hit_leaf  = tlb_leaf_mem[hit_idx];
    assign hit_base  = tlb_base_mem[hit_idx];
    assign hit_level = tlb_key_reg[hit_idx].level;
    assign hit_pa    = hit_level ? {hit_base[31:22], va[21:0]} : {hit_base[31:12], va[11:0]};
    assign walk_pa   = walk_level_reg ? {pte[29:20], walk_vaddr_reg[21:0]}
                                      : {pte[29:10], walk_vaddr_reg[11:0]};
    assign fill_slot = walk_fetch_reg ? TLB_IDX_W'(fetch_ptr_reg)
                     : TLB_IDX_W'(FETCH_TLB_ENTRIES) + TLB_IDX_W'(data_ptr_reg);

    always_comb
    begin
        res        = '0;
        res_action = ACT_PHYS;
        has_result = 1'b0;
        do_start   = 1'b0;
        do_next    = 1'b0;
        do_fill    = 1'b0;
        do_end     = 1'b0;
        do_flush   = 1'b0;
        unique case (kind_reg)
            KIND_TRANSLATE:
            begin
                has_result = 1'b1;
                if (walk_active_reg)
                    res_action = ACT_BUSY;
                else if (priv == PRIV_M || !satp_mode_reg)
                    res.phys_addr = va;
                else if (hit)
                begin
                    if (leaf_allows(hit_leaf, fetch, store, priv, sum_reg, mxr_reg))
                    begin
                        res.phys_addr = hit_pa;
                        res.tlb_hit   = 1'b1;
                    end
                    else
                    begin
                        res_action          = ACT_FAULT;
                        res.fault_cause     = cause_of(fetch, store);
                        res.fault_value     = va;
                        res.trap_pc         = fetch ? va : item_reg.cur_pc;
                        res.fault_privilege = priv;
                    end
                end
                else
                begin
                    do_start      = 1'b1;
                    res_action    = ACT_PTE_READ;
                    res.phys_addr = {root_ppn_reg[19:0], va[31:22], 2'b00};
                end
            end
            KIND_RESPONSE:
            begin
                if (walk_active_reg)
                begin
                    has_result = 1'b1;
                    do_end     = 1'b1;
                    res_action = ACT_FAULT;
                    if (!item_reg.pte_ok || !pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R]))
                        res_action = ACT_FAULT;
                    else if (!pte[PTE_R] && !pte[PTE_W] && !pte[PTE_X])
                    begin
                        if (!pte[PTE_U] && !pte[PTE_A] && !pte[PTE_D] && walk_level_reg)
                        begin
                            do_end        = 1'b0;
                            do_next       = 1'b1;
                            res_action    = ACT_PTE_READ;
                            res.phys_addr = {pte[29:10], walk_vaddr_reg[21:12], 2'b00};
                        end
                    end
                    else if (leaf_allows(pte, walk_fetch_reg, walk_store_reg, walk_priv_reg,
                                         walk_sum_reg, walk_mxr_reg)
                             && !(walk_level_reg && pte[19:10] != 10'd0))
                    begin
                        do_fill       = 1'b1;
                        res_action    = ACT_PHYS;
                        res.phys_addr = walk_pa;
                    end
                    if (res_action == ACT_FAULT)
                    begin
                        res.fault_cause     = cause_of(walk_fetch_reg, walk_store_reg);
                        res.fault_value     = walk_vaddr_reg;
                        res.trap_pc         = walk_pc_reg;
                        res.fault_privilege = walk_priv_reg;
                    end
                end
            end
            KIND_FLUSH:  do_flush = 1'b1;
            default:     ;
        endcase
    end

    assign sts.has_result = has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg   <= '0;
            fetch_ptr_reg   <= '0;
            data_ptr_reg    <= '0;
            walk_active_reg <= 1'b0;
            walk_vaddr_reg  <= '0;
            walk_fetch_reg  <= 1'b0;
            walk_store_reg  <= 1'b0;
            walk_priv_reg   <= '0;
            walk_sum_reg    <= 1'b0;
            walk_mxr_reg    <= 1'b0;
            walk_level_reg  <= 1'b0;
            walk_pc_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_flush)
                tlb_valid_reg <= '0;
            if (do_start)
            begin
                walk_active_reg <= 1'b1;
                walk_vaddr_reg  <= va;
                walk_fetch_reg  <= fetch;
                walk_store_reg  <= store;
                walk_priv_reg   <= priv;
                walk_sum_reg    <= sum_reg;
                walk_mxr_reg    <= mxr_reg;
                walk_level_reg  <= 1'b1;
                walk_pc_reg     <= fetch ? va : item_reg.cur_pc;
            end
            if (do_next)
                walk_level_reg <= 1'b0;
            if (do_end)
                walk_active_reg <= 1'b0;
            if (do_fill)
            begin
                walk_active_reg          <= 1'b0;
                tlb_valid_reg[fill_slot] <= 1'b1;
                if (walk_fetch_reg)
                    fetch_ptr_reg <= (fetch_ptr_reg == FETCH_PTR_W'(FETCH_TLB_ENTRIES - 1)) ?
                                     '0 : fetch_ptr_reg + 1'b1;
                else
                    data_ptr_reg <= (data_ptr_reg == DATA_PTR_W'(DATA_TLB_ENTRIES - 1)) ?
                                    '0 : data_ptr_reg + 1'b1;
            end
        end
    end

    // Entry payloads are only read behind a set valid bit.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_fill)
        begin
            tlb_key_reg[fill_slot].tag   <= walk_level_reg ? {10'd0, walk_vaddr_reg[31:22]}
                                                           : walk_vaddr_reg[31:12];
            tlb_key_reg[fill_slot].root  <= root_ppn_reg;
            tlb_key_reg[fill_slot].asid  <= asid_reg;
            tlb_key_reg[fill_slot].priv  <= walk_priv_reg;
            tlb_key_reg[fill_slot].sum   <= walk_sum_reg;
            tlb_key_reg[fill_slot].mxr   <= walk_mxr_reg;
            tlb_key_reg[fill_slot].level <= walk_level_reg;
            tlb_leaf_mem[fill_slot]      <= pte;
            tlb_base_mem[fill_slot]      <= walk_level_reg ? {walk_pa[31:22], 22'd0}
                                                           : {walk_pa[31:12], 12'd0};
        end
    end

    assign out_action = out_action_reg;
    assign out_item   = out_item_reg;

endmodule

// File: design/stpw_ctrl.sv
`include "sv32_tlb_page_walker_unit_assert.svh"

module stpw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output stpw_pkg::ctrl_cmd_t  cmd,
    input  stpw_pkg::ctrl_sts_t  sts
);
    import stpw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.has_result || slot_free)
                begin
                    cmd.commit     = 1'b1;
                    cmd.load       = sts.has_result;
                    out_valid_next = sts.has_result || out_valid_next;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `STPW_ASSERT_IMP(a_load_needs_slot, clk, rst_n, cmd.load, slot_free, "result overwrote pending output")
    `STPW_ASSERT_IMP(a_load_with_commit, clk, rst_n, cmd.load, cmd.commit, "output load without commit")
    `STPW_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.load, out_valid_reg, "loaded result not presented")

endmodule
